// ===== src/acpf_pkg.sv =====
// Shared types, widths and codes of the ADC channel averager.
`timescale 1ns / 1ps

package acpf_pkg;

	// Channel count and saturation limit of the per-channel sample counters.
	localparam int CHANNELS  = 16;
	localparam int COUNT_MAX = 65535;

	// Field and store widths.
	localparam int CH_W      = 4;
	localparam int SMP_W     = 12;
	localparam int CNT_W     = 16;
	localparam int SUM_W     = 28;
	localparam int VAL_W     = 16;
	localparam int FRAC_W    = 4;
	localparam int THR_W     = 13;
	localparam int DIV_W     = SUM_W + FRAC_W;
	localparam int STEP_W    = $clog2(DIV_W);
	localparam int CH_IDX_W  = $clog2(CHANNELS);
	localparam int CH_WIDE_W = CH_W + CH_IDX_W;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_BOARD_CHANNEL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VALID_ABOVE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BRICK_ABOVE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_USB_ABOVE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_USB_BELOW     = 3'd4;

	// Register values after reset.
	localparam logic [CH_W-1:0]  RST_BOARD_CHANNEL = 4'd6;
	localparam logic [SMP_W-1:0] RST_VALID_ABOVE   = 12'd310;
	localparam logic [SMP_W-1:0] RST_BRICK_ABOVE   = 12'd2792;
	localparam logic [SMP_W-1:0] RST_USB_ABOVE     = 12'd2482;
	localparam logic [THR_W-1:0] RST_USB_BELOW     = 13'd3414;

	// Power flag bit positions.
	localparam int FLAG_BRICK = 0;
	localparam int FLAG_USB   = 1;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_AVG    = 2'd1,
		CMD_LATEST = 2'd2,
		CMD_STATUS = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_FIN
	} state_t;

	// Status returned by the divider to the sequencer.
	typedef struct packed {
		logic             done;
		logic [VAL_W-1:0] quotient;
	} div_stat_t;

endpackage

// ===== src/acpf_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module acpf_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [acpf_pkg::DIV_W-1:0]    dividend,
	input  logic [acpf_pkg::CNT_W-1:0]    divisor,
	output acpf_pkg::div_stat_t           stat
);

	logic                           busy_q;
	logic                           done_q;
	logic [acpf_pkg::STEP_W-1:0]    step_q;
	logic [acpf_pkg::DIV_W-1:0]     dq_q;
	logic [acpf_pkg::CNT_W-1:0]     rem_q;
	logic [acpf_pkg::CNT_W-1:0]     dvs_q;
	logic [acpf_pkg::CNT_W:0]       shifted;
	logic [acpf_pkg::CNT_W:0]       diff;
	logic                           ge;

	// Shift in the next dividend bit and try one subtraction.
	assign shifted = {rem_q, dq_q[acpf_pkg::DIV_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = (shifted >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == acpf_pkg::STEP_W'(acpf_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The quotient bits fill the dividend register from the bottom as it empties.
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[acpf_pkg::DIV_W-2:0], ge};
			rem_q <= ge ? diff[acpf_pkg::CNT_W-1:0] : shifted[acpf_pkg::CNT_W-1:0];
		end
	end

	assign stat.done     = done_q;
	assign stat.quotient = dq_q[acpf_pkg::VAL_W-1:0];

endmodule

// ===== src/adc_channel_averager_power_flags.sv =====
// Top level of the multichannel ADC averager with board-supply power flags.
// Add sample, read latest, read status and a read average of an empty channel give their result
// straight from the execute state; any other read average first runs through the 32
// steps of the bit-serial divider. A new request is taken only once the last one is finished,
// and later while a waiting result holds the output register.
// Reset clears every channel store, the board count and both flag sets, and loads the thresholds.
`timescale 1ns / 1ps

module adc_channel_averager_power_flags (
	input  logic                              clk,
	input  logic                              arst_n,
	// Request stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [15:0]                       s_tdata,   // channel[3:0], sample_value[15:4]
	input  logic [1:0]                        s_tuser,   // command[1:0]
	// Result stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [31:0]                       m_tdata,   // value[15:0], board_voltage_count[27:16],
	                                                     // power_flags[29:28], sticky_flags[31:30]
	// Configuration writes.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [acpf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [acpf_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// Configuration registers.
	logic [acpf_pkg::CH_W-1:0]  board_channel_q;
	logic [acpf_pkg::SMP_W-1:0] valid_above_q;
	logic [acpf_pkg::SMP_W-1:0] brick_above_q;
	logic [acpf_pkg::SMP_W-1:0] usb_above_q;
	logic [acpf_pkg::THR_W-1:0] usb_below_q;

	// Per-channel stores.
	logic [acpf_pkg::SUM_W-1:0] sum_q    [acpf_pkg::CHANNELS];
	logic [acpf_pkg::CNT_W-1:0] count_q  [acpf_pkg::CHANNELS];
	logic [acpf_pkg::SMP_W-1:0] latest_q [acpf_pkg::CHANNELS];
	logic [acpf_pkg::VAL_W-1:0] held_q   [acpf_pkg::CHANNELS];

	// Board supply state.
	logic [acpf_pkg::SMP_W-1:0] board_q;
	logic [1:0]                 flags_q;
	logic [1:0]                 sticky_q;

	// Captured request.
	acpf_pkg::cmd_t             cmd_q;
	logic [acpf_pkg::CH_W-1:0]  ch_q;
	logic [acpf_pkg::SMP_W-1:0] sample_q;

	acpf_pkg::state_t           state_q;
	acpf_pkg::state_t           state_d;

	logic                       out_valid_q;
	logic [31:0]                out_data_q;

	logic [acpf_pkg::CH_WIDE_W-1:0] ch_wide;
	logic [acpf_pkg::CH_IDX_W-1:0]  idx;
	logic                           ch_ok;
	logic                           out_free;
	logic                           out_load;
	logic                           exec_we;
	logic                           fin_we;
	logic                           div_start;
	logic                           board_hit;
	logic [acpf_pkg::SMP_W-1:0]     board_d;
	logic [1:0]                     flags_d;
	logic [1:0]                     sticky_d;
	logic [acpf_pkg::VAL_W-1:0]     value_d;
	logic [acpf_pkg::DIV_W-1:0]     dividend;
	acpf_pkg::div_stat_t            div_stat;

	// The channel field may be wider or narrower than the store index, so it is
	// widened first and then both range-checked and cut down to the index.
	assign ch_wide = {{acpf_pkg::CH_IDX_W{1'b0}}, ch_q};
	assign idx     = ch_wide[acpf_pkg::CH_IDX_W-1:0];
	assign ch_ok   = (ch_wide < acpf_pkg::CH_WIDE_W'(acpf_pkg::CHANNELS));

	// Configuration is always taken; it must only arrive while the block is idle, which the block itself does not enforce.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_channel_q <= acpf_pkg::RST_BOARD_CHANNEL;
			valid_above_q   <= acpf_pkg::RST_VALID_ABOVE;
			brick_above_q   <= acpf_pkg::RST_BRICK_ABOVE;
			usb_above_q     <= acpf_pkg::RST_USB_ABOVE;
			usb_below_q     <= acpf_pkg::RST_USB_BELOW;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				acpf_pkg::REG_BOARD_CHANNEL: board_channel_q <= cfg_data[acpf_pkg::CH_W-1:0];
				acpf_pkg::REG_VALID_ABOVE:   valid_above_q   <= cfg_data[acpf_pkg::SMP_W-1:0];
				acpf_pkg::REG_BRICK_ABOVE:   brick_above_q   <= cfg_data[acpf_pkg::SMP_W-1:0];
				acpf_pkg::REG_USB_ABOVE:     usb_above_q     <= cfg_data[acpf_pkg::SMP_W-1:0];
				acpf_pkg::REG_USB_BELOW:     usb_below_q     <= cfg_data[acpf_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// A board sample only replaces the board count when it clears the validity
	// threshold, but the flags are re-evaluated on every sample of that channel.
	assign board_hit = (cmd_q == acpf_pkg::CMD_ADD) && ch_ok && (ch_q == board_channel_q);

	always_comb begin
		board_d  = board_q;
		flags_d  = flags_q;
		if (board_hit) begin
			if (sample_q > valid_above_q) begin
				board_d = sample_q;
			end
			flags_d[acpf_pkg::FLAG_BRICK] = (board_d > brick_above_q);
			flags_d[acpf_pkg::FLAG_USB]   = (board_d > usb_above_q) &&
			                                ({1'b0, board_d} < usb_below_q);
		end
		sticky_d = sticky_q | flags_d;
	end

	// The average is (sum << 4) / count, giving four fraction bits.
	assign dividend = {sum_q[idx], {acpf_pkg::FRAC_W{1'b0}}};

	acpf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (count_q[idx]),
		.stat     (div_stat)
	);

	// The result can be written once the output register is empty or being emptied.
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		out_load  = 1'b0;
		exec_we   = 1'b0;
		fin_we    = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			acpf_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = acpf_pkg::ST_EXEC;
				end
			end
			acpf_pkg::ST_EXEC: begin
				if ((cmd_q == acpf_pkg::CMD_AVG) && ch_ok && (count_q[idx] != '0)) begin
					div_start = 1'b1;
					state_d   = acpf_pkg::ST_DIV;
				end else if (out_free) begin
					out_load = 1'b1;
					exec_we  = 1'b1;
					state_d  = acpf_pkg::ST_IDLE;
				end
			end
			acpf_pkg::ST_DIV: begin
				if (div_stat.done) begin
					state_d = acpf_pkg::ST_FIN;
				end
			end
			acpf_pkg::ST_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					fin_we   = 1'b1;
					state_d  = acpf_pkg::ST_IDLE;
				end
			end
			default: state_d = acpf_pkg::ST_IDLE;
		endcase
	end

	// Value field of the result.
	always_comb begin
		value_d = '0;
		if (state_q == acpf_pkg::ST_FIN) begin
			value_d = div_stat.quotient;
		end else if (ch_ok) begin
			unique case (cmd_q)
				acpf_pkg::CMD_AVG:    value_d = held_q[idx];
				acpf_pkg::CMD_LATEST: value_d = {latest_q[idx], {acpf_pkg::FRAC_W{1'b0}}};
				acpf_pkg::CMD_ADD,
				acpf_pkg::CMD_STATUS: value_d = '0;
				default:              value_d = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acpf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q    <= acpf_pkg::cmd_t'(s_tuser);
			ch_q     <= s_tdata[acpf_pkg::CH_W-1:0];
			sample_q <= s_tdata[acpf_pkg::CH_W +: acpf_pkg::SMP_W];
		end
	end

	// Channel stores. A saturated counter stops the sum too; only the latest
	// sample keeps following the input.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < acpf_pkg::CHANNELS; i++) begin
				sum_q[i]    <= '0;
				count_q[i]  <= '0;
				latest_q[i] <= '0;
				held_q[i]   <= '0;
			end
		end else if (exec_we && (cmd_q == acpf_pkg::CMD_ADD) && ch_ok) begin
			latest_q[idx] <= sample_q;
			if (count_q[idx] < acpf_pkg::CNT_W'(acpf_pkg::COUNT_MAX)) begin
				sum_q[idx]   <= sum_q[idx] + {{(acpf_pkg::SUM_W - acpf_pkg::SMP_W){1'b0}}, sample_q};
				count_q[idx] <= count_q[idx] + 1'b1;
			end
		end else if (fin_we) begin
			held_q[idx]  <= div_stat.quotient;
			sum_q[idx]   <= '0;
			count_q[idx] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_q  <= '0;
			flags_q  <= '0;
			sticky_q <= '0;
		end else if (exec_we && board_hit) begin
			board_q  <= board_d;
			flags_q  <= flags_d;
			sticky_q <= sticky_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {sticky_d, flags_d, board_d, value_d};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== src/acpf_checker.sv =====
// Port-level assertions for the ADC averager, bound to its top level.
`timescale 1ns / 1ps

module acpf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// One request at a time: after a request is taken the block is busy.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while the previous one is still in work");

	// A fresh result only comes from work in progress, never out of idle.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without a request in work");

	// Every current power flag is also set in the sticky copy.
	a_sticky_covers: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[31:30] & m_tdata[29:28]) == m_tdata[29:28]))
		else $error("power flag set without its sticky copy");

	// A stalled result holds.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

bind adc_channel_averager_power_flags acpf_checker u_acpf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
